>>> rtl/pdcf_pkg.sv
// Shared types and constants of the PWM duty capture filter.
// Depends on nothing; every other file of the block uses it by scoped names.
package pdcf_pkg;

   // Counter width of the high and low sample counters, and number of channels.
   localparam int COUNT_WIDTH = 16;
   localparam int CHANNELS    = 4;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Field widths fixed by the interface.
   localparam int CHAN_W    = 2;
   localparam int PINS_W    = 4;
   localparam int DUTY_W    = 7;
   localparam int TIMEOUT_W = 16;
   localparam int DIV_W     = 7;

   // Divider: quotients never exceed 100, so seven quotient bits suffice.
   localparam int QUO_W  = 7;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int DEN_W  = COUNT_WIDTH + 1;
   localparam int NUM_W  = DEN_W + QUO_W - 1;

   localparam logic [DUTY_W-1:0] PERCENT = DUTY_W'(100);

   // Input operation codes.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Register file.
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_DIVISOR = 1'b1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(3000);
   localparam logic [DIV_W-1:0]     DIVISOR_RESET = DIV_W'(2);

   // Depth of the queue between the capture front end and the arithmetic back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One finished capture (or a flagged failure) handed to the back end.
   typedef struct packed {
      logic [CHAN_W-1:0]      channel;
      logic                   timed_out;
      logic [COUNT_WIDTH-1:0] high_count;
      logic [COUNT_WIDTH-1:0] low_count;
   } meas_type;

   // One result beat.
   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DUTY_W-1:0] duty;
      logic              timed_out;
   } rsp_type;

endpackage

>>> rtl/pdcf_front.sv
// Capture front end: edge waits with timeout, high and low sample counting.
// Depends on pdcf_pkg; feeds pdcf_queue with finished captures.
module pdcf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              op,
   input  logic [pdcf_pkg::CHAN_W-1:0]       channel,
   input  logic [pdcf_pkg::PINS_W-1:0]       pin_levels,
   input  logic [pdcf_pkg::TIMEOUT_W-1:0]    timeout_limit,
   output logic                              push_valid,
   output pdcf_pkg::meas_type                push_entry
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_LOW,
      PH_WAIT_HIGH,
      PH_COUNT_HIGH,
      PH_COUNT_LOW
   } phase_type;

   phase_type                            phase_ff, phase_in;
   logic [pdcf_pkg::CHAN_W-1:0]          active_ff, active_in;
   logic [pdcf_pkg::TIMEOUT_W-1:0]       wait_ff, wait_in, wait_inc;
   logic [pdcf_pkg::COUNT_WIDTH-1:0]     high_ff, high_in, low_ff, low_in;
   logic                                 pin;
   logic                                 bad_channel;

   assign pin         = pin_levels[active_ff];
   assign wait_inc    = wait_ff + pdcf_pkg::TIMEOUT_W'(1);
   assign bad_channel = 32'(channel) >= 32'(pdcf_pkg::CHANNELS);

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      wait_in    = wait_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      push_valid = 1'b0;
      push_entry = '{channel: active_ff, timed_out: 1'b1,
                     high_count: high_ff, low_count: low_ff};
      if (accept) begin
         if (op == pdcf_pkg::OP_START) begin
            if (phase_ff == PH_IDLE) begin
               if (bad_channel) begin
                  push_valid         = 1'b1;
                  push_entry.channel = channel;
               end else begin
                  active_in = channel;
                  wait_in   = '0;
                  high_in   = '0;
                  low_in    = '0;
                  phase_in  = PH_WAIT_LOW;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_WAIT_LOW, PH_WAIT_HIGH: begin
                  if ((phase_ff == PH_WAIT_LOW && !pin) ||
                      (phase_ff == PH_WAIT_HIGH && pin)) begin
                     wait_in = '0;
                     if (phase_ff == PH_WAIT_LOW) begin
                        phase_in = PH_WAIT_HIGH;
                     end else begin
                        high_in  = pdcf_pkg::COUNT_WIDTH'(1);
                        phase_in = PH_COUNT_HIGH;
                     end
                  end else if (wait_inc == '0 || wait_inc >= timeout_limit) begin
                     wait_in    = '0;
                     phase_in   = PH_IDLE;
                     push_valid = 1'b1;
                  end else begin
                     wait_in = wait_inc;
                  end
               end
               PH_COUNT_HIGH: begin
                  if (pin) begin
                     if (high_ff != '1) high_in = high_ff + pdcf_pkg::COUNT_WIDTH'(1);
                  end else begin
                     low_in   = pdcf_pkg::COUNT_WIDTH'(1);
                     phase_in = PH_COUNT_LOW;
                  end
               end
               PH_COUNT_LOW: begin
                  if (!pin) begin
                     if (low_ff != '1) low_in = low_ff + pdcf_pkg::COUNT_WIDTH'(1);
                  end else begin
                     phase_in             = PH_IDLE;
                     push_valid           = 1'b1;
                     push_entry.timed_out = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         active_ff <= '0;
         wait_ff   <= '0;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         wait_ff   <= wait_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

endmodule

>>> rtl/pdcf_queue.sv
// Short queue of finished captures between the front end and the back end.
// Depends on pdcf_pkg for the entry type and depth.
module pdcf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pdcf_pkg::meas_type push_entry,
   input  logic               pop_ready,
   output logic               head_valid,
   output pdcf_pkg::meas_type head_entry,
   output logic               full
);

   pdcf_pkg::meas_type                slot_ff [pdcf_pkg::QUEUE_DEPTH];
   logic [pdcf_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [pdcf_pkg::QCNT_W-1:0]       count_ff;
   logic                              do_push, do_pop;

   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign full       = count_ff == pdcf_pkg::QCNT_W'(pdcf_pkg::QUEUE_DEPTH);
   assign do_push    = push_valid && !full;
   assign do_pop     = pop_ready && head_valid;

   function automatic logic [pdcf_pkg::QPTR_W-1:0] ptr_next(
      input logic [pdcf_pkg::QPTR_W-1:0] p);
      ptr_next = (32'(p) == pdcf_pkg::QUEUE_DEPTH - 1) ? '0 : p + pdcf_pkg::QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            slot_ff[wr_ptr_ff] <= push_entry;
            wr_ptr_ff          <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop) count_ff <= count_ff + pdcf_pkg::QCNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - pdcf_pkg::QCNT_W'(1);
      end
   end

endmodule

>>> rtl/pdcf_back.sv
// Arithmetic back end: duty percentage by a shared bit-serial divider, the
// per-channel low-pass filter store, and the result register. Depends on pdcf_pkg.
module pdcf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  pdcf_pkg::meas_type             head_entry,
   output logic                           pop_ready,
   input  logic [pdcf_pkg::DIV_W-1:0]     filter_divisor,
   input  logic                           rsp_pop,
   output logic                           rsp_valid,
   output pdcf_pkg::rsp_type              rsp
);

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_WRITE} state_type;
   typedef enum logic [1:0] {P_DUTY, P_NEW, P_OLD} pass_type;

   state_type                           state_ff;
   pass_type                            pass_ff;
   pdcf_pkg::meas_type                  entry_ff;
   logic [pdcf_pkg::NUM_W-1:0]          rem_ff, den_sh_ff, rem_in;
   logic [pdcf_pkg::NUM_W:0]            trial;
   logic [pdcf_pkg::QUO_W-1:0]          quo_ff, quo_in;
   logic [pdcf_pkg::STEP_W-1:0]         step_ff;
   logic [pdcf_pkg::DUTY_W-1:0]         part_ff, result_ff;
   logic [pdcf_pkg::DUTY_W-1:0]         filt_ff [pdcf_pkg::CHANNELS];
   logic [pdcf_pkg::DUTY_W-1:0]         old_duty, duty_clamp;
   logic [pdcf_pkg::DUTY_W:0]           new_sum;
   logic [pdcf_pkg::DIV_W-1:0]          divisor_eff;
   logic [pdcf_pkg::DEN_W-1:0]          total;
   logic [pdcf_pkg::CH_IDX_W-1:0]       idx;
   logic                                fits, out_free;
   pdcf_pkg::rsp_type                   rsp_ff;
   logic                                rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign pop_ready = state_ff == B_IDLE && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // A divisor of zero behaves as one.
   assign divisor_eff = (filter_divisor == '0) ? pdcf_pkg::DIV_W'(1) : filter_divisor;
   assign idx         = pdcf_pkg::CH_IDX_W'(entry_ff.channel);
   assign old_duty    = filt_ff[idx];

   always_comb begin
      total = pdcf_pkg::DEN_W'(entry_ff.high_count) + pdcf_pkg::DEN_W'(entry_ff.low_count);
      if (total == '0) total = pdcf_pkg::DEN_W'(1);
   end

   // One restoring division step per cycle.
   assign trial  = {1'b0, rem_ff} - {1'b0, den_sh_ff};
   assign fits   = !trial[pdcf_pkg::NUM_W];
   assign rem_in = fits ? trial[pdcf_pkg::NUM_W-1:0] : rem_ff;
   assign quo_in = {quo_ff[pdcf_pkg::QUO_W-2:0], fits};

   assign duty_clamp = (quo_in > pdcf_pkg::PERCENT) ? pdcf_pkg::PERCENT : quo_in;
   assign new_sum    = {1'b0, part_ff} + {1'b0, old_duty} - {1'b0, quo_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pass_ff      <= P_DUTY;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pdcf_pkg::CHANNELS; i++) filt_ff[i] <= '0;
      end else begin
         if (rsp_pop) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (head_valid && out_free) begin
                  if (head_entry.timed_out) begin
                     rsp_ff       <= '{channel: head_entry.channel, duty: '0,
                                       timed_out: 1'b1};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     entry_ff <= head_entry;
                     state_ff <= B_MUL;
                  end
               end
            end
            B_MUL: begin
               rem_ff    <= pdcf_pkg::NUM_W'(entry_ff.high_count)
                            * pdcf_pkg::NUM_W'(pdcf_pkg::PERCENT);
               den_sh_ff <= pdcf_pkg::NUM_W'(total) << (pdcf_pkg::QUO_W - 1);
               quo_ff    <= '0;
               step_ff   <= pdcf_pkg::STEP_W'(pdcf_pkg::QUO_W - 1);
               pass_ff   <= P_DUTY;
               state_ff  <= B_DIV;
            end
            B_DIV: begin
               rem_ff    <= rem_in;
               quo_ff    <= quo_in;
               den_sh_ff <= den_sh_ff >> 1;
               step_ff   <= step_ff - pdcf_pkg::STEP_W'(1);
               if (step_ff == '0) begin
                  quo_ff    <= '0;
                  step_ff   <= pdcf_pkg::STEP_W'(pdcf_pkg::QUO_W - 1);
                  den_sh_ff <= pdcf_pkg::NUM_W'(divisor_eff) << (pdcf_pkg::QUO_W - 1);
                  unique case (pass_ff)
                     P_DUTY: begin
                        rem_ff  <= pdcf_pkg::NUM_W'(duty_clamp);
                        pass_ff <= P_NEW;
                     end
                     P_NEW: begin
                        part_ff <= quo_in;
                        rem_ff  <= pdcf_pkg::NUM_W'(old_duty);
                        pass_ff <= P_OLD;
                     end
                     P_OLD: begin
                        result_ff <= (new_sum > {1'b0, pdcf_pkg::PERCENT}) ?
                                     pdcf_pkg::PERCENT : new_sum[pdcf_pkg::DUTY_W-1:0];
                        pass_ff   <= P_DUTY;
                        state_ff  <= B_WRITE;
                     end
                     default: begin
                        pass_ff  <= P_DUTY;
                        state_ff <= B_IDLE;
                     end
                  endcase
               end
            end
            B_WRITE: begin
               if (out_free) begin
                  filt_ff[idx] <= result_ff;
                  rsp_ff       <= '{channel: entry_ff.channel, duty: result_ff,
                                    timed_out: 1'b0};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/pwm_duty_capture_filter.sv
// Top level of the PWM duty capture filter: register file and the wiring of
// front end, queue and back end. Depends on pdcf_pkg, pdcf_front, pdcf_queue, pdcf_back.
//
// Use: the request channel is a queue write port (push, full). A start beat
// (req_op high) picks the channel to measure; sample beats (req_op low) carry
// the pin levels, one bit per channel. The front end waits for the pin to go
// low and then high, each wait bounded by timeout_limit sample beats, then
// counts high and low samples until the pin rises again. The response channel
// is a queue read port (empty, pop): the oldest result sits on the rsp_ ports
// while empty is low and leaves on a pop.
// Throughput: one beat every cycle while the two-entry hand-off queue has room.
// Order of events, with the back end free: a timeout or invalid-start result is
// pushed into the queue and then loaded into the result register; a completed
// measurement is pushed into the queue, then the back end loads it, multiplies the
// high count by 100, runs three seven-step divisions and writes the result register.
// A stalled receiver holds the result register; the back end waits, the queue
// fills and then full is raised. Reset (synchronous, active high) empties both
// queues, idles the front end, clears the four filter values and loads the
// register defaults. Registers: timeout_limit at byte address 0, filter_divisor
// at address 4; write them only while no measurement is in progress.
module pwm_duty_capture_filter (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              push,
   output logic                              full,
   input  logic                              req_op,
   input  logic [pdcf_pkg::CHAN_W-1:0]       req_channel,
   input  logic [pdcf_pkg::PINS_W-1:0]       req_pin_levels,
   // Response channel
   output logic                              empty,
   input  logic                              pop,
   output logic [pdcf_pkg::CHAN_W-1:0]       rsp_result_channel,
   output logic [pdcf_pkg::DUTY_W-1:0]       rsp_duty_percent,
   output logic                              rsp_timed_out,
   // Register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pdcf_pkg::ADDR_W-1:0]       paddr,
   input  logic [pdcf_pkg::DATA_W-1:0]       pwdata,
   output logic [pdcf_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   logic [pdcf_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [pdcf_pkg::DIV_W-1:0]     divisor_ff;
   logic                           reg_write;
   logic                           req_accept;
   logic                           push_valid, head_valid, pop_ready, rsp_valid;
   pdcf_pkg::meas_type             push_entry, head_entry;
   pdcf_pkg::rsp_type              rsp;

   // The register port never inserts wait states. Only address bit 2 selects
   // the register, so each register also answers at its unaligned aliases.
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pdcf_pkg::TIMEOUT_RESET;
         divisor_ff <= pdcf_pkg::DIVISOR_RESET;
      end else if (reg_write) begin
         unique case (paddr[2])
            pdcf_pkg::REG_TIMEOUT: timeout_ff <= pwdata[pdcf_pkg::TIMEOUT_W-1:0];
            pdcf_pkg::REG_DIVISOR: divisor_ff <= pwdata[pdcf_pkg::DIV_W-1:0];
            default:               timeout_ff <= timeout_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         pdcf_pkg::REG_TIMEOUT: prdata = pdcf_pkg::DATA_W'(timeout_ff);
         pdcf_pkg::REG_DIVISOR: prdata = pdcf_pkg::DATA_W'(divisor_ff);
         default:               prdata = '0;
      endcase
   end

   // A request beat is taken whenever the hand-off queue has room.
   assign req_accept = push && !full;

   pdcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .op            (req_op),
      .channel       (req_channel),
      .pin_levels    (req_pin_levels),
      .timeout_limit (timeout_ff),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   pdcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_ready  (pop_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (full)
   );

   pdcf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop_ready      (pop_ready),
      .filter_divisor (divisor_ff),
      .rsp_pop        (pop && !empty),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp)
   );

   assign empty              = !rsp_valid;
   assign rsp_result_channel = rsp.channel;
   assign rsp_duty_percent   = rsp.duty;
   assign rsp_timed_out      = rsp.timed_out;

endmodule

>>> rtl/pdcf_checker.sv
// Port-level checks of the PWM duty capture filter, bound to its top level.
// Depends on pdcf_pkg and on pwm_duty_capture_filter.
module pdcf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [pdcf_pkg::CHAN_W-1:0]   rsp_result_channel,
   input logic [pdcf_pkg::DUTY_W-1:0]   rsp_duty_percent,
   input logic                          rsp_timed_out
);

   // Reset leaves no result waiting and room for requests.
   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("result or full flag survived reset");

   // A flagged result never carries a duty value.
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_timed_out |-> rsp_duty_percent == '0)
      else $error("timed-out result with non-zero duty");

   // The filtered duty stays within percent range.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_duty_percent <= pdcf_pkg::PERCENT)
      else $error("duty above one hundred percent");

   // A waiting result is held until it is popped.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_duty_percent) &&
                         $stable(rsp_result_channel) && $stable(rsp_timed_out))
      else $error("waiting result changed before pop");

endmodule

bind pwm_duty_capture_filter pdcf_checker u_pdcf_checker (.*);
